FILE: sv/rhcb_pkg.sv
package rhcb_pkg;

  // rolling window
  localparam int WINDOW = 7;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int XOR_SHIFT = 5;

  // field widths
  localparam int BYTE_W = 8;
  localparam int HASH_W = 32;
  localparam int LEN_W = 24;
  localparam int BS_W = 17;
  localparam logic [BS_W-1:0] BS_RESET = BS_W'(64);
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // queue between the hash front and the modulo back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // remainder unit: quotient bits retired per cycle
  localparam int DIV_BITS = 4;
  localparam int DIV_STEPS = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              first;
  } rhcb_item_t;

endpackage

FILE: sv/rolling_hash_chunk_boundary.sv
// Rolling-hash chunk boundary detector.
//
// Data channel (data_valid / data_stall, byte_value, first_of_stream): one
// byte per transfer. first_of_stream clears the window, the hash parts and
// the chunk length before that byte is hashed.
// Result channel (result_valid / result_stall): one transfer per byte with
// rolling_hash, chunk_end (hash mod chunk_mod == chunk_mod - 1) and
// chunk_length, counting this byte and saturating at its maximum.
// Config channel (cfg_valid / cfg_ready, cfg_data): writes chunk_mod;
// cfg_ready is always high. Write only while the block is idle.
//
// The remainder unit in the back end sets the pace; it retires 4 hash
// bits per cycle in RUN and then passes through FINISH, one queued item
// at a time, while the queue takes further bytes meanwhile. The
// hash itself is updated in the front end on the transfer cycle and queued.
// Reset (rst, synchronous) clears the hash state, the queue and the chunk
// length, and loads chunk_mod with 64. When the receiver stalls, the
// result holds; the back end finishes one more item behind it, the queue
// fills, and then data_stall rises.
module rolling_hash_chunk_boundary
  import rhcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              first_of_stream,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [HASH_W-1:0] rolling_hash,
  output logic              chunk_end,
  output logic [LEN_W-1:0]  chunk_length,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BS_W-1:0]   cfg_data
);

  logic [BS_W-1:0] chunk_mod;
  logic            take;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  rhcb_item_t      front_item;
  rhcb_item_t      q_head;

  // Config register: always ready, taken on every valid cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_mod <= BS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      chunk_mod <= cfg_data;
    end
  end

  // Hold the data side off only when the queue has no room.
  assign data_stall = q_full;
  assign take       = data_valid && !data_stall;

  // Front end: advance the window and the three hash parts per byte.
  rhcb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .byte_value      (byte_value),
    .first_of_stream (first_of_stream),
    .item            (front_item)
  );

  // Queue decouples the hash update from the boundary test.
  rhcb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // Back end: remainder by chunk_mod, chunk length, result register.
  rhcb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .chunk_mod    (chunk_mod),
    .q_valid      (q_valid),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .rolling_hash (rolling_hash),
    .chunk_end    (chunk_end),
    .chunk_length (chunk_length)
  );

endmodule

FILE: sv/rhcb_front.sv
module rhcb_front
  import rhcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              first_of_stream,
  output rhcb_item_t        item
);

  localparam logic [HASH_W-1:0] WIN_MUL = HASH_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic [BYTE_W-1:0] window_bytes [WINDOW];
  logic [SLOT_W-1:0] window_slot;
  logic [HASH_W-1:0] window_sum;
  logic [HASH_W-1:0] weighted_sum;
  logic [HASH_W-1:0] shift_xor;

  logic [SLOT_W-1:0] slot_cur;
  logic [SLOT_W-1:0] slot_next;
  logic [BYTE_W-1:0] old_byte;
  logic [HASH_W-1:0] sum_cur;
  logic [HASH_W-1:0] weighted_cur;
  logic [HASH_W-1:0] xor_cur;
  logic [HASH_W-1:0] byte_ext;
  logic [HASH_W-1:0] window_sum_next;
  logic [HASH_W-1:0] weighted_sum_next;
  logic [HASH_W-1:0] shift_xor_next;

  // a first byte sees the cleared state
  always_comb begin
    slot_cur     = first_of_stream ? '0 : window_slot;
    old_byte     = first_of_stream ? '0 : window_bytes[slot_cur];
    sum_cur      = first_of_stream ? '0 : window_sum;
    weighted_cur = first_of_stream ? '0 : weighted_sum;
    xor_cur      = first_of_stream ? '0 : shift_xor;
    byte_ext     = HASH_W'(byte_value);

    weighted_sum_next = weighted_cur - sum_cur + WIN_MUL * byte_ext;
    window_sum_next   = sum_cur + byte_ext - HASH_W'(old_byte);
    shift_xor_next    = (xor_cur << XOR_SHIFT) ^ byte_ext;
    slot_next         = (slot_cur == SLOT_LAST) ? '0 : slot_cur + SLOT_W'(1);

    item.hash  = window_sum_next + weighted_sum_next + shift_xor_next;
    item.first = first_of_stream;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) window_bytes[i] <= '0;
      window_slot  <= '0;
      window_sum   <= '0;
      weighted_sum <= '0;
      shift_xor    <= '0;
    end else if (take) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (SLOT_W'(i) == slot_cur) window_bytes[i] <= byte_value;
        else if (first_of_stream) window_bytes[i] <= '0;
      end
      window_slot  <= slot_next;
      window_sum   <= window_sum_next;
      weighted_sum <= weighted_sum_next;
      shift_xor    <= shift_xor_next;
    end
  end

endmodule

FILE: sv/rhcb_queue.sv
module rhcb_queue
  import rhcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rhcb_item_t push_item,
  input  logic       pop,
  output rhcb_item_t head,
  output logic       not_empty,
  output logic       full
);

  rhcb_item_t entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == Q_CNT_W'(Q_DEPTH));

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + Q_CNT_W'(1);
      else if (pop && !push) count <= count - Q_CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

FILE: sv/rhcb_back.sv
module rhcb_back
  import rhcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BS_W-1:0]   chunk_mod,
  input  logic              q_valid,
  input  rhcb_item_t        q_item,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [HASH_W-1:0] rolling_hash,
  output logic              chunk_end,
  output logic [LEN_W-1:0]  chunk_length
);

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t state;
  logic [DIV_CNT_W-1:0] step;
  logic [HASH_W-1:0]    dividend;
  logic [BS_W-1:0]      rem;
  logic [HASH_W-1:0]    hash_hold;
  logic                 first_hold;
  logic [LEN_W-1:0]     bytes_in_chunk;

  logic              out_free;
  logic              retire;
  logic              load;
  logic [BS_W-1:0]   rem_next;
  logic [HASH_W-1:0] dividend_next;
  logic              end_hit;
  logic [LEN_W-1:0]  len_base;
  logic [LEN_W-1:0]  len;

  assign out_free = !result_valid || !result_stall;
  assign retire   = (state == FINISH) && out_free;
  assign load     = q_valid && ((state == IDLE) || retire);
  assign q_pop    = load;

  // restoring remainder, DIV_BITS dividend bits per cycle
  always_comb begin
    logic [BS_W:0]     t;
    logic [BS_W-1:0]   r;
    logic [HASH_W-1:0] dv;
    r  = rem;
    dv = dividend;
    for (int k = 0; k < DIV_BITS; k++) begin
      t  = {r, dv[HASH_W-1]};
      dv = dv << 1;
      if (t >= {1'b0, chunk_mod}) t = t - {1'b0, chunk_mod};
      r = t[BS_W-1:0];
    end
    rem_next      = r;
    dividend_next = dv;
  end

  always_comb begin
    end_hit  = (chunk_mod != '0) && (rem == chunk_mod - BS_W'(1));
    len_base = first_hold ? '0 : bytes_in_chunk;
    len      = (len_base == LEN_MAX) ? LEN_MAX : len_base + LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      step           <= '0;
      result_valid   <= 1'b0;
      bytes_in_chunk <= '0;
    end else begin
      if (retire) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      if (load) begin
        dividend   <= q_item.hash;
        hash_hold  <= q_item.hash;
        first_hold <= q_item.first;
        rem        <= '0;
        step       <= '0;
      end
      unique case (state)
        IDLE: begin
          if (load) state <= RUN;
        end
        RUN: begin
          rem      <= rem_next;
          dividend <= dividend_next;
          step     <= step + DIV_CNT_W'(1);
          if (step == STEP_LAST) state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            rolling_hash   <= hash_hold;
            chunk_end      <= end_hit;
            chunk_length   <= len;
            bytes_in_chunk <= end_hit ? '0 : len;
            state          <= load ? RUN : IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_run_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == RUN && step == STEP_LAST) |=> state == FINISH)
    else $error("remainder did not finish after last step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid)) |-> $past(state == FINISH))
    else $error("result raised outside finish");

  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> chunk_length != '0)
    else $error("zero chunk length on result");

endmodule

FILE: verif/rolling_hash_chunk_boundary_tb.sv
`timescale 1ns / 100ps

module rolling_hash_chunk_boundary_tb;
  import rhcb_pkg::*;

  localparam int N_DIR = 23;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 103;
  localparam int RAND_BS_PHASE = 2;
  localparam int HOLD_PHASE = 7;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  // one result transfer: hash, chunk boundary flag, chunk length
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              brk;
    logic [LEN_W-1:0]  len;
  } chunk_res_t;

  // directed row: optional chunk_mod write, then one byte; res is used
  // only when typed is set, otherwise the predictor supplies the result
  typedef struct packed {
    logic              cfg_wr;
    logic [BS_W-1:0]   cfg_val;
    logic [BYTE_W-1:0] b;
    logic              fos;
    logic              typed;
    chunk_res_t        res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              data_valid = 1'b0;
  logic              data_stall;
  logic [BYTE_W-1:0] byte_value = '0;
  logic              first_of_stream = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [HASH_W-1:0] rolling_hash;
  logic              chunk_end;
  logic [LEN_W-1:0]  chunk_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [BS_W-1:0]   cfg_data = '0;

  // predictor copy of the block state
  logic [BS_W-1:0]   bs_cur = BS_RESET;
  logic [BYTE_W-1:0] win_bytes_q [WINDOW] = '{default: '0};
  int                win_pos = 0;
  logic [HASH_W-1:0] sum_win = '0;
  logic [HASH_W-1:0] sum_wtd = '0;
  logic [HASH_W-1:0] xor_reg = '0;
  logic [LEN_W-1:0]  run_len = '0;

  chunk_res_t        hash_results_due [$];
  int                err_cnt = 0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  logic              hold_req = 1'b0;

  // Directed stimulus: extremes of the byte, stream restarts, a hash that
  // lands exactly on chunk_mod - 1, and the odd block sizes (zero, one,
  // the 17-bit maximum and the top of the normal range).
  dir_row_t dir_tab [N_DIR] = '{
    '{1'b0, 17'd0,      8'h00, 1'b1, 1'b1, '{32'd0,    1'b0, 24'd1}},
    '{1'b0, 17'd0,      8'hFF, 1'b1, 1'b1, '{32'd2295, 1'b0, 24'd1}},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 17'd0,      8'h07, 1'b1, 1'b1, '{32'd63,   1'b1, 24'd1}},
    '{1'b0, 17'd0,      8'h01, 1'b0, 1'b0, '0},
    '{1'b1, 17'd1,      8'h12, 1'b1, 1'b1, '{32'd162,  1'b1, 24'd1}},
    '{1'b0, 17'd0,      8'hFF, 1'b0, 1'b0, '0},
    '{1'b1, 17'd0,      8'h3F, 1'b1, 1'b1, '{32'd567,  1'b0, 24'd1}},
    '{1'b0, 17'd0,      8'hA5, 1'b0, 1'b0, '0},
    '{1'b1, 17'd131071, 8'hFF, 1'b1, 1'b1, '{32'd2295, 1'b0, 24'd1}},
    '{1'b0, 17'd0,      8'h5A, 1'b0, 1'b0, '0},
    '{1'b1, 17'd65536,  8'h01, 1'b1, 1'b1, '{32'd9,    1'b0, 24'd1}},
    '{1'b1, 17'd2,      8'h01, 1'b1, 1'b1, '{32'd9,    1'b1, 24'd1}},
    '{1'b0, 17'd0,      8'h02, 1'b1, 1'b1, '{32'd18,   1'b0, 24'd1}},
    '{1'b0, 17'd0,      8'h02, 1'b0, 1'b0, '0},
    '{1'b1, 17'd64,     8'h55, 1'b0, 1'b0, '0}
  };

  // block sizes of the random phases; the RAND_BS_PHASE entry is replaced
  // by a random value in the normal range
  logic [BS_W-1:0] phase_bs [N_PHASES] = '{
    17'd2, 17'd64, 17'd0, 17'd1, 17'd3, 17'd131071, 17'd0, 17'd64, 17'd65536
  };

  rolling_hash_chunk_boundary i_dut (
    .clk             (clk),
    .rst             (rst),
    .data_valid      (data_valid),
    .data_stall      (data_stall),
    .byte_value      (byte_value),
    .first_of_stream (first_of_stream),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .rolling_hash    (rolling_hash),
    .chunk_end       (chunk_end),
    .chunk_length    (chunk_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the predicted hash state by one byte and return the result
  // the block must produce for it.
  function automatic chunk_res_t roll_byte(input logic [BYTE_W-1:0] c, input logic fos);
    chunk_res_t        r;
    logic [HASH_W-1:0] bs32;
    if (fos) begin
      // a new stream drops the window, all hash parts and the open chunk
      foreach (win_bytes_q[k]) win_bytes_q[k] = '0;
      win_pos = 0;
      sum_win = '0;
      sum_wtd = '0;
      xor_reg = '0;
      run_len = '0;
    end
    // the weighted sum loses the old window sum before the window moves
    sum_wtd = sum_wtd - sum_win + HASH_W'(WINDOW) * HASH_W'(c);
    sum_win = sum_win + HASH_W'(c) - HASH_W'(win_bytes_q[win_pos]);
    win_bytes_q[win_pos] = c;
    win_pos = (win_pos == WINDOW - 1) ? 0 : win_pos + 1;
    xor_reg = (xor_reg << XOR_SHIFT) ^ HASH_W'(c);
    r.hash = sum_win + sum_wtd + xor_reg;
    // block size zero has no modulus and never marks a boundary
    bs32 = HASH_W'(bs_cur);
    r.brk = (bs32 != 0) && ((r.hash % bs32) == bs32 - 1);
    // hold the length at its maximum until the next boundary
    r.len = (run_len == LEN_MAX) ? LEN_MAX : run_len + 1'b1;
    run_len = r.brk ? '0 : r.len;
    return r;
  endfunction

  // Offer one byte, hold it until the transfer, then queue its result.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fos, input logic typed,
                           input chunk_res_t typed_res);
    chunk_res_t pred;
    data_valid <= 1'b1;
    byte_value <= b;
    first_of_stream <= fos;
    do @(posedge clk); while (data_stall);
    pred = roll_byte(b, fos);
    hash_results_due.push_back(typed ? typed_res : pred);
  endtask

  // Drop valid for a few cycles now and then, per the current idle rate.
  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Stop offering bytes and wait for every queued result to come back.
  task automatic drain_results();
    data_valid <= 1'b0;
    while (hash_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_chunk_mod(input logic [BS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bs_cur = v;
  endtask

  // Result side: check each transfer against the oldest expectation, then
  // pick the stall for the next cycle. A hold request from the stimulus
  // turns into a long stall, counted down here.
  initial begin : result_side
    chunk_res_t want;
    int         hold_left;
    logic       hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (hash_results_due.size() == 0) begin
          $display("%0t: result with none expected: hash %h end %b len %0d",
                   $time, rolling_hash, chunk_end, chunk_length);
          err_cnt++;
        end else begin
          want = hash_results_due.pop_front();
          if (rolling_hash !== want.hash) begin
            $display("%0t: rolling_hash expected %h actual %h", $time, want.hash, rolling_hash);
            err_cnt++;
          end
          if (chunk_end !== want.brk) begin
            $display("%0t: chunk_end expected %b actual %b", $time, want.brk, chunk_end);
            err_cnt++;
          end
          if (chunk_length !== want.len) begin
            $display("%0t: chunk_length expected %0d actual %0d", $time, want.len,
                     chunk_length);
            err_cnt++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] b;
    logic              fos;
    logic [BS_W-1:0]   bs;
    int                pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run with the first idling mix
    tx_idle_pct = 27;
    rx_idle_pct = 67;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_wr) begin
        drain_results();
        write_chunk_mod(dir_tab[i].cfg_val);
      end
      send_byte(dir_tab[i].b, dir_tab[i].fos, dir_tab[i].typed, dir_tab[i].res);
      sender_gap();
    end

    // Random phases: long streams of random bytes with rare restarts and
    // frequent all-zero or all-one bytes. Idling moves from a busy sender to
    // a busy receiver and then to none at all.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph / 3)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 67;
        end
        1: begin
          tx_idle_pct = 67;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      bs = (ph == RAND_BS_PHASE) ? BS_W'($urandom_range(65536, 2)) : phase_bs[ph];
      write_chunk_mod(bs);
      // stall the result side long enough to back the block up into its input
      if (ph == HOLD_PHASE) hold_req <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(9);
        case (pick)
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = BYTE_W'($urandom_range(255));
        endcase
        fos = (n == 0) || ($urandom_range(99) < 3);
        send_byte(b, fos, 1'b0, '0);
        sender_gap();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[rolling_hash_chunk_boundary] OK");
    end else begin
      $display("[rolling_hash_chunk_boundary] ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("[rolling_hash_chunk_boundary] ERROR");
    $finish;
  end

endmodule
